FILE: rtl/mfrd_pkg.sv
package mfrd_pkg;

    // Register reset values and indexes
    localparam logic [15:0] OPCODE_RESET   = 16'h03FC;
    localparam logic [30:0] MAX_MU_RESET   = 31'd100000;
    localparam logic        CFG_IDX_OPCODE = 1'b0;
    localparam logic        CFG_IDX_MAX_MU = 1'b1;

    // Body layout
    localparam logic [2:0]  POS_OPC_LO     = 3'd0;
    localparam logic [2:0]  POS_OPC_HI     = 3'd1;
    localparam logic [2:0]  POS_FLT_FIRST  = 3'd3;
    localparam logic [2:0]  POS_SAT        = 3'd7;

    // Scaling
    localparam logic signed [8:0] EXP_BIAS       = 9'sd3;
    localparam logic [7:0]        MAX_DOWN_STEPS = 8'd9;
    localparam logic [31:0]       MUL_TEN        = 32'd10;
    // floor(x / 10) == (x * RECIP_TEN) >> 35 for every 32-bit x
    localparam logic [31:0]       RECIP_TEN      = 32'hCCCC_CCCD;
    localparam int                RECIP_SHIFT    = 35;
    localparam logic [31:0]       ROUND_HALF     = 32'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [30:0] value_milliunits;
    } t_out_item;

    typedef struct packed {
        logic        ok;
        logic        neg;
        logic        up;
        logic [7:0]  count;
        logic [31:0] mag;
    } t_scale_req;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

FILE: rtl/mfrd_scaler.sv
module mfrd_scaler (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  mfrd_pkg::t_scale_req i_req,
    input  logic [30:0]          i_max_mu,
    input  logic                 i_take,
    output logic                 o_idle,
    output logic                 o_done,
    output mfrd_pkg::t_out_item  o_result
);
    import mfrd_pkg::*;

    t_state      r_state, n_state;
    logic        r_ok, n_ok;
    logic        r_neg, n_neg;
    logic        r_up, n_up;
    logic [7:0]  r_cnt, n_cnt;
    logic [31:0] r_mag, n_mag;

    logic [31:0] w_opa;
    logic [31:0] w_opb;
    logic [63:0] w_prod;
    logic        w_ovf;
    logic        w_finish;
    logic        w_acc;

    // Shared multiplier: times ten going up, reciprocal of ten going down
    assign w_opa  = (!r_up && r_cnt == 8'd1) ? r_mag + ROUND_HALF : r_mag;
    assign w_opb  = r_up ? MUL_TEN : RECIP_TEN;
    assign w_prod = 64'(w_opa) * 64'(w_opb);
    assign w_ovf  = r_up && (w_prod[63:31] != '0);

    assign w_finish = !r_ok || (r_cnt == '0) || (r_mag == '0);

    always_comb begin
        n_state = r_state;
        n_ok    = r_ok;
        n_neg   = r_neg;
        n_up    = r_up;
        n_cnt   = r_cnt;
        n_mag   = r_mag;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN;
                    n_ok    = i_req.ok;
                    n_neg   = i_req.neg;
                    n_up    = i_req.up;
                    n_cnt   = i_req.count;
                    n_mag   = i_req.mag;
                end
            end
            S_RUN: begin
                if (w_finish) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - 8'd1;
                    n_mag = r_up ? w_prod[31:0] : 32'(w_prod[63:RECIP_SHIFT]);
                    if (w_ovf) begin
                        n_ok = 1'b0;
                    end
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_ok  <= n_ok;
        r_neg <= n_neg;
        r_up  <= n_up;
        r_cnt <= n_cnt;
        r_mag <= n_mag;
    end

    // Negative values pass only when they rounded to zero
    assign w_acc = r_ok && (!r_neg || r_mag == '0) && !r_mag[31]
                   && (r_mag[30:0] <= i_max_mu);

    assign o_idle                    = (r_state == S_IDLE);
    assign o_done                    = (r_state == S_DONE);
    assign o_result.accepted         = w_acc;
    assign o_result.value_milliunits = w_acc ? r_mag[30:0] : '0;

    a_up_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_up && r_ok) |-> !r_mag[31])
        else $error("upscale magnitude out of range while still valid");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && !w_finish) |=> (r_cnt == $past(r_cnt) - 8'd1))
        else $error("step counter did not advance");

    a_down_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && !r_up && !w_finish) |=> (r_mag <= $past(r_mag)))
        else $error("downscale step grew the magnitude");

    a_down_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && !r_up) |-> (r_cnt <= MAX_DOWN_STEPS))
        else $error("downscale step count too large");

endmodule

FILE: rtl/medical_float_response_decoder.sv
// After the last byte the result passes through the scaling iterations, the done state
//   and the output register load.
// Throughput: one byte per cycle while collecting, unless a last byte waits for the
//   previous result to be taken; one body at a time through scaling.
// The scaling loop runs on one shared 32x32 multiplier, one power of ten per cycle.
// Reset (synchronous, active low) empties the body capture and the output register
//   and loads opcode 0x03FC and a ceiling of 100000 milli-units.
module medical_float_response_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mfrd_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mfrd_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [30:0]         i_cfg_data
);
    import mfrd_pkg::*;

    // Configuration
    logic [15:0] r_exp_opcode;
    logic [30:0] r_max_mu;

    // Body capture
    logic [2:0]  r_pos, n_pos;
    logic [15:0] r_opcode, n_opcode;
    logic [31:0] r_float, n_float;

    // Output register
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic        w_accept;
    logic        w_start;
    logic        w_take;
    logic        sc_idle;
    logic        sc_done;
    t_out_item   sc_result;
    t_scale_req  w_req;

    logic signed [8:0]  w_pw;
    logic        [8:0]  w_steps;
    logic        [24:0] w_mag;
    logic        [2:0]  w_fpos;

    // Hold off all bytes while scaling and a last byte while the previous result is untaken
    assign o_in_ready = sc_idle && !(r_out_valid && i_in_item.last_byte);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_start    = w_accept && i_in_item.last_byte;
    assign w_take     = sc_done && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_opcode <= OPCODE_RESET;
            r_max_mu     <= MAX_MU_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_OPCODE: r_exp_opcode <= i_cfg_data[15:0];
                CFG_IDX_MAX_MU: r_max_mu     <= i_cfg_data;
                default:        r_max_mu     <= r_max_mu;
            endcase
        end
    end

    // Drop the byte into its slot: opcode bytes 0-1, float bytes 3-6, skip the rest
    assign w_fpos = r_pos - POS_FLT_FIRST;

    always_comb begin
        n_opcode = r_opcode;
        n_float  = r_float;
        priority if (r_pos == POS_OPC_LO) begin
            n_opcode[7:0] = i_in_item.data_byte;
        end else if (r_pos == POS_OPC_HI) begin
            n_opcode[15:8] = i_in_item.data_byte;
        end else if (r_pos >= POS_FLT_FIRST && r_pos != POS_SAT) begin
            n_float[w_fpos[1:0]*8 +: 8] = i_in_item.data_byte;
        end else begin
            // Flags byte and trailing bytes leave the capture alone
            n_float = r_float;
        end
        n_pos = (r_pos == POS_SAT) ? r_pos : r_pos + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_opcode <= '0;
            r_float  <= '0;
        end else if (w_accept) begin
            r_pos    <= i_in_item.last_byte ? 3'd0 : n_pos;
            r_opcode <= i_in_item.last_byte ? 16'd0 : n_opcode;
            r_float  <= i_in_item.last_byte ? 32'd0 : n_float;
        end
    end

    // Set up the scaling job: magnitude, sign and decimal shift of the mantissa
    assign w_pw    = 9'(signed'(n_float[31:24])) + EXP_BIAS;
    assign w_steps = 9'(-w_pw);
    assign w_mag   = n_float[23] ? 25'(-{1'b1, n_float[23:0]}) : {1'b0, n_float[23:0]};

    always_comb begin
        w_req.ok  = (n_pos == POS_SAT) && (n_opcode == r_exp_opcode);
        w_req.neg = n_float[23];
        w_req.up  = !w_pw[8];
        w_req.mag = 32'(w_mag);
        priority if (!w_pw[8]) begin
            w_req.count = w_pw[7:0];
        end else if (w_steps > 9'(MAX_DOWN_STEPS)) begin
            // Divisor beyond 10^9 always rounds the mantissa to zero
            w_req.count = '0;
            w_req.mag   = '0;
        end else begin
            w_req.count = w_steps[7:0];
        end
    end

    mfrd_scaler u_scaler (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_req    (w_req),
        .i_max_mu (r_max_mu),
        .i_take   (w_take),
        .o_idle   (sc_idle),
        .o_done   (sc_done),
        .o_result (sc_result)
    );

    // Output register: load on finish, clear when the item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_take) begin
            r_out_item <= sc_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_item.accepted) |-> (r_out_item.value_milliunits == '0))
        else $error("rejected item carries a value");

    a_busy_no_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !sc_idle |-> !o_in_ready)
        else $error("input ready while scaling");

    a_out_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && sc_result.accepted) |-> (sc_result.value_milliunits <= r_max_mu))
        else $error("accepted value above ceiling");

endmodule

FILE: tb/sv/medical_float_response_checker.sv
`timescale 1ns / 1ps
module medical_float_response_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  mfrd_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  mfrd_pkg::t_out_item i_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [30:0]         i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import mfrd_pkg::*;

    // Largest magnitudes that still fit a signed 32-bit value
    localparam longint unsigned POS_LIMIT = 64'd2147483647;
    localparam longint unsigned NEG_LIMIT = 64'd2147483648;
    localparam int              DIV_LIMIT = 9;

    logic [15:0] want_opcode;
    logic [30:0] ceiling_mu;
    logic [2:0]  body_pos;
    logic [15:0] body_opcode;
    logic [31:0] body_float;
    t_out_item   expected_readings[$];

    // Scale the captured float to milli-units and apply the body checks.
    function automatic t_out_item decode_reading(input logic [2:0] count,
                                                 input logic [15:0] opc,
                                                 input logic [31:0] flt);
        int                expo;
        int                pw;
        longint            mant;
        longint unsigned   mag;
        longint unsigned   div;
        logic              neg;
        logic              fits;
        t_out_item         res;
        expo = int'($signed(flt[31:24]));
        mant = longint'($signed(flt[23:0]));
        neg  = mant < 0;
        mag  = neg ? longint'(-mant) : mant;
        pw   = expo + int'(EXP_BIAS);
        fits = (count == POS_SAT) && (opc == want_opcode);
        if (pw >= 0) begin
            for (int i = 0; i < pw && mag != 0 && fits; i++) begin
                mag = mag * 10;
                if (mag > (neg ? NEG_LIMIT : POS_LIMIT))
                    fits = 1'b0;
            end
        end else if (-pw > DIV_LIMIT) begin
            mag = 0;
        end else begin
            div = 1;
            for (int i = 0; i < -pw; i++)
                div = div * 10;
            mag = (mag + div / 2) / div;
        end
        // a negative value survives only when it rounds to zero
        if (fits && neg && mag != 0)
            fits = 1'b0;
        if (fits && mag > longint'(ceiling_mu))
            fits = 1'b0;
        res.accepted         = fits;
        res.value_milliunits = fits ? mag[30:0] : '0;
        return res;
    endfunction

    function automatic void take_byte(input t_in_item item);
        case (body_pos)
            POS_OPC_LO: body_opcode[7:0]  = item.data_byte;
            POS_OPC_HI: body_opcode[15:8] = item.data_byte;
            default: begin
                if (body_pos >= POS_FLT_FIRST && body_pos < POS_SAT)
                    body_float[8 * (body_pos - POS_FLT_FIRST) +: 8] = item.data_byte;
            end
        endcase
        if (body_pos != POS_SAT)
            body_pos = body_pos + 3'd1;
        if (item.last_byte) begin
            expected_readings.push_back(decode_reading(body_pos, body_opcode, body_float));
            body_pos    = '0;
            body_opcode = '0;
            body_float  = '0;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            want_opcode  = OPCODE_RESET;
            ceiling_mu   = MAX_MU_RESET;
            body_pos     = '0;
            body_opcode  = '0;
            body_float   = '0;
            expected_readings.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IDX_OPCODE)
                    want_opcode = i_cfg_data[15:0];
                else if (i_cfg_idx == CFG_IDX_MAX_MU)
                    ceiling_mu = i_cfg_data;
            end
            if (i_in_valid && i_in_ready)
                take_byte(i_in_item);
            if (i_out_valid && i_out_ready) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t: unexpected reading, accepted %0b value %0d", $time,
                             i_out_item.accepted, i_out_item.value_milliunits);
                    o_fail_count++;
                end else begin
                    want = expected_readings.pop_front();
                    if (i_out_item.accepted !== want.accepted) begin
                        $display("%0t: accepted mismatch, expected %0b, got %0b", $time,
                                 want.accepted, i_out_item.accepted);
                        o_fail_count++;
                    end
                    if (i_out_item.value_milliunits !== want.value_milliunits) begin
                        $display("%0t: value mismatch, expected %0d, got %0d", $time,
                                 want.value_milliunits, i_out_item.value_milliunits);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending <= expected_readings.size();
    end

endmodule

FILE: tb/sv/medical_float_response_decoder_test.sv
`timescale 1ns / 1ps
module medical_float_response_decoder_test;
    import mfrd_pkg::*;

    // Cycles without any item moving before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // Worst-case scaling latency after the last byte, with margin
    localparam int DRAIN_TAIL  = 16;
    // Input bytes per random phase
    localparam int PHASE_BYTES = 350;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        cfg_we;
    logic        cfg_idx;
    logic [30:0] cfg_data;

    int          fail_count;
    int          pending;
    int          in_idle_pct   = 0;
    int          out_stall_pct = 0;
    int          sent_bytes    = 0;
    int          quiet_cycles  = 0;
    logic [15:0] cur_opcode    = OPCODE_RESET;

    medical_float_response_decoder DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    medical_float_response_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    // Stall the result side at the rate of the current phase.
    always @(posedge clk) begin
        out_ready <= (out_stall_pct == 0) || ($urandom_range(99) >= out_stall_pct);
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Present one byte, optionally after a random gap, and hold it until taken.
    task automatic send_byte(input logic [7:0] data, input logic last);
        t_in_item item;
        item.data_byte = data;
        item.last_byte = last;
        if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (!in_ready);
        sent_bytes++;
    endtask

    // Send a body of len bytes; bytes past the seventh are random filler.
    task automatic send_body(input logic [15:0] opc, input logic [7:0] flags,
                             input logic [31:0] flt, input int len);
        logic [55:0] layout;
        layout = {flt, flags, opc};
        for (int i = 0; i < len; i++)
            send_byte(i < 7 ? layout[8 * i +: 8] : 8'($urandom), i == len - 1);
    endtask

    // Mostly exponents that land near the milli-unit scale, mantissas of random width.
    function automatic logic [31:0] pick_float();
        logic [7:0]  expo;
        logic [23:0] mant;
        int          width;
        width = $urandom_range(1, 24);
        mant  = 24'($urandom) & 24'((32'h1 << width) - 32'h1);
        if ($urandom_range(3) == 0)
            mant = -mant;
        if ($urandom_range(9) < 8)
            expo = 8'($urandom_range(0, 16) - 10);
        else
            expo = 8'($urandom);
        return {expo, mant};
    endfunction

    task automatic send_random_body();
        logic [15:0] opc;
        logic [31:0] flt;
        int          len;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            // noise: arbitrary bytes of arbitrary length
            opc = 16'($urandom);
            flt = $urandom;
            len = $urandom_range(1, 12);
        end else begin
            if ($urandom_range(9) < 8)
                opc = cur_opcode;
            else if ($urandom_range(1) == 0)
                opc = 16'($urandom);
            else
                opc = cur_opcode ^ (16'h1 << $urandom_range(15));
            flt = pick_float();
            if (pick < 25)
                len = $urandom_range(1, 6);
            else if (pick < 35)
                len = $urandom_range(8, 12);
            else
                len = 7;
        end
        send_body(opc, 8'($urandom), flt, len);
    endtask

    // Drop valid, wait for every expected reading, then let the pipeline empty.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // Write both registers on back-to-back cycles; only called while idle.
    task automatic write_config(input logic [15:0] opc, input logic [30:0] ceiling);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_IDX_OPCODE;
        cfg_data <= 31'(opc);
        @(posedge clk);
        cfg_idx  <= CFG_IDX_MAX_MU;
        cfg_data <= ceiling;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_opcode = opc;
    endtask

    initial begin
        int phase_start;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        cfg_we   <= 1'b0;
        cfg_idx  <= CFG_IDX_OPCODE;
        cfg_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed bodies against the reset opcode and ceiling.
        send_body(OPCODE_RESET, 8'h00, 32'hFD00_04D2, 1);   // body of one byte
        send_body(OPCODE_RESET, 8'hFF, 32'hFD00_04D2, 7);   // plain 1234 mU
        send_body(OPCODE_RESET, 8'h00, 32'h0000_0064, 7);   // upscale to the ceiling
        send_body(OPCODE_RESET, 8'h00, 32'hFD01_86A1, 7);   // one above the ceiling
        send_body(OPCODE_RESET, 8'h00, 32'hFC00_000F, 7);   // 1.5 rounds up to 2
        send_body(OPCODE_RESET, 8'h00, 32'hFCFF_FFFC, 7);   // -0.4 rounds to 0
        send_body(OPCODE_RESET, 8'h00, 32'hFCFF_FFFB, 7);   // -0.5 rounds to -1
        send_body(OPCODE_RESET, 8'h00, 32'h7F00_0001, 7);   // upscale overflow
        send_body(OPCODE_RESET, 8'h00, 32'h807F_FFFF, 7);   // divisor far too large
        send_body(OPCODE_RESET, 8'h00, 32'hFA80_0000, 7);   // most negative mantissa
        send_body(OPCODE_RESET, 8'h00, 32'h007F_FFFF, 7);   // NaN code, no special case
        send_body(16'h03FD, 8'h00, 32'hFD00_04D2, 7);       // wrong opcode
        send_body(OPCODE_RESET, 8'h5A, 32'h0000_0000, 9);   // trailing bytes ignored
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    in_idle_pct   = 0;
                    out_stall_pct = 0;
                    write_config(16'h0000, 31'h7FFF_FFFF);
                end
                1: begin
                    in_idle_pct   = 78;
                    out_stall_pct = 0;
                    write_config(16'hFFFF, 31'h0);
                end
                2: begin
                    in_idle_pct   = 0;
                    out_stall_pct = 78;
                    write_config(16'($urandom), 31'($urandom_range(1000, 50_000_000)));
                end
                default: begin
                    in_idle_pct   = 36;
                    out_stall_pct = 36;
                    write_config(16'hA5C3, 31'($urandom_range(1, 2_000_000)));
                end
            endcase
            phase_start = sent_bytes;
            while (sent_bytes - phase_start < PHASE_BYTES)
                send_random_body();
            settle();
        end

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mfrd_pkg.sv
rtl/mfrd_scaler.sv
rtl/medical_float_response_decoder.sv
tb/sv/medical_float_response_checker.sv
tb/sv/medical_float_response_decoder_test.sv
